// ===== rtl/gcode_motion_to_robot_moves_assert.svh =====
// Assertion macros shared by the motion converter RTL.
`ifndef GCODE_MOTION_TO_ROBOT_MOVES_ASSERT_SVH
`define GCODE_MOTION_TO_ROBOT_MOVES_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define GMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define GMR_ASSERT_NEXT(lbl, pre, post, msg) \
  `GMR_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== rtl/gmr_pkg.sv =====
// Shared types, codes and constants of the motion converter.
package gmr_pkg;

  typedef enum logic [1:0] {
    CMD_LINEAR = 2'd0,
    CMD_CW     = 2'd1,
    CMD_CCW    = 2'd2,
    CMD_OTHER  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_EXT_ON  = 3'd0,
    KIND_EXT_OFF = 3'd1,
    KIND_FIRST   = 3'd2,
    KIND_LINEAR  = 3'd3,
    KIND_CIRC    = 3'd4
  } kind_e;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;

  localparam int CFG_BITS    = 22;
  localparam int ORIGIN_BITS = 22;
  localparam int HEIGHT_BITS = 20;
  localparam int ZW          = 34;

  localparam logic [31:0] GAIN_Q30     = 32'd652032874;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_I, S_SQ_J, S_SQRT, S_SQRT_W, S_ANG_S, S_ANG_S_W, S_ANG_E,
    S_ANG_E_W, S_GAIN, S_ROT, S_ROT_W, S_VIA, S_EVT, S_MOVE
  } seq_state_e;

  typedef enum logic [1:0] {
    CS_IDLE, CS_NORM, CS_STEP
  } cor_state_e;

  typedef struct packed {
    logic start;
    logic rotate;
  } cor_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } cor_status_t;

  // Arctangent of 2^-k as a fraction of a full turn scaled by 2^32.
  function automatic logic [31:0] turn_atan(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gmr_if.sv =====
// Request channel interfaces for motion commands and emitted moves.
interface gmr_cmd_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic                         has_x;
  logic                         has_y;
  logic                         has_z;
  logic                         has_e;
  logic                         has_i;
  logic                         has_j;
  logic signed [COORD_BITS-1:0] x_value;
  logic signed [COORD_BITS-1:0] y_value;
  logic signed [COORD_BITS-1:0] z_value;
  logic signed [COORD_BITS-1:0] i_offset;
  logic signed [COORD_BITS-1:0] j_offset;

  modport source(output valid, command, has_x, has_y, has_z, has_e, has_i, has_j,
                 x_value, y_value, z_value, i_offset, j_offset, input ready);
  modport sink(input valid, command, has_x, has_y, has_z, has_e, has_i, has_j,
               x_value, y_value, z_value, i_offset, j_offset, output ready);
endinterface

interface gmr_res_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   kind;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;
  logic signed [COORD_BITS-1:0] via_x;
  logic signed [COORD_BITS-1:0] via_y;
  logic signed [COORD_BITS-1:0] via_z;
  logic                         last;

  modport source(output valid, kind, end_x, end_y, end_z, via_x, via_y, via_z, last,
                 input ready);
  modport sink(input valid, kind, end_x, end_y, end_z, via_x, via_y, via_z, last,
               output ready);
endinterface

// ===== rtl/gmr_cordic.sv =====
// Iterative CORDIC unit shared between vectoring (angle) and rotation (sin/cos).
module gmr_cordic #(
  parameter int CW           = 35,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gmr_pkg::cor_req_t         req_i,
  input  logic signed [CW-1:0]      x_i,
  input  logic signed [CW-1:0]      y_i,
  input  logic signed [gmr_pkg::ZW-1:0] z_i,
  output gmr_pkg::cor_status_t      status_o,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic [31:0]               z_o
);

  localparam int KW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int ZW = gmr_pkg::ZW;

  gmr_pkg::cor_state_e cs_q, cs_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d, xs, ys, ay;
  logic signed [ZW-1:0] z_q, z_d, at;
  logic [KW-1:0]        k_q, k_d;
  logic                 rot_q, rot_d, done_q, done_d, up;

  always_comb begin
    cs_d   = cs_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    k_d    = k_q;
    rot_d  = rot_q;
    done_d = 1'b0;
    xs     = x_q >>> k_q;
    ys     = y_q >>> k_q;
    ay     = y_q[CW-1] ? -y_q : y_q;
    up     = rot_q ? !z_q[ZW-1] : (y_q <= 0);
    at     = signed'(ZW'(gmr_pkg::turn_atan(5'(k_q))));
    case (cs_q)
      gmr_pkg::CS_IDLE: begin
        if (req_i.start) begin
          rot_d = req_i.rotate;
          k_d   = '0;
          if (req_i.rotate) begin
            x_d  = x_i;
            y_d  = y_i;
            z_d  = z_i;
            cs_d = gmr_pkg::CS_STEP;
          end else begin
            if (x_i[CW-1]) begin
              x_d = -x_i;
              y_d = -y_i;
              z_d = signed'(ZW'(gmr_pkg::HALF_TURN));
            end else begin
              x_d = x_i;
              y_d = y_i;
              z_d = '0;
            end
            cs_d = gmr_pkg::CS_NORM;
          end
        end
      end
      gmr_pkg::CS_NORM: begin
        if (x_q == '0 && y_q == '0) begin
          z_d    = '0;
          done_d = 1'b1;
          cs_d   = gmr_pkg::CS_IDLE;
        end else if (~|x_q[CW-1:30] && ~|ay[CW-1:30]) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else begin
          cs_d = gmr_pkg::CS_STEP;
        end
      end
      gmr_pkg::CS_STEP: begin
        if (up) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
        k_d = k_q + 1'b1;
        if (k_q == KW'(CORDIC_STEPS - 1)) begin
          done_d = 1'b1;
          cs_d   = gmr_pkg::CS_IDLE;
        end
      end
      default: cs_d = gmr_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= gmr_pkg::CS_IDLE;
      done_q <= 1'b0;
      k_q    <= '0;
      rot_q  <= 1'b0;
    end else begin
      cs_q   <= cs_d;
      done_q <= done_d;
      k_q    <= k_d;
      rot_q  <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign status_o.done = done_q;
  assign status_o.busy = (cs_q != gmr_pkg::CS_IDLE);
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q[31:0];

endmodule

// ===== rtl/gmr_isqrt.sv =====
// Bit-pair integer square root of a 64-bit value, two radicand bits a cycle.
module gmr_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] n_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] rem_t, trial;

  assign rem_t = {rem_q, n_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q <= n_q << 2;
      if (rem_t >= trial) begin
        rem_q  <= 34'(rem_t - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= 34'(rem_t);
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/gcode_motion_to_robot_moves.sv =====
// Top level of the motion command to robot move converter.
// One command is taken at a time. A command that emits nothing frees the input in the next
// cycle and a linear move passes through the event and move states to the output register. An
// arc first squares I and J, takes the bit-pair square root for the radius, runs two atan2
// passes on the shared CORDIC unit (each with normalising shifts ahead of CORDIC_STEPS
// iterations), then a rotation pass and the via point; these two units take most of its time.
// An extruder event, when due, goes out as a separate request ahead of the move.
`include "gcode_motion_to_robot_moves_assert.svh"

module gcode_motion_to_robot_moves #(
  parameter int COORD_BITS   = 24,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gmr_cmd_if.sink                        cmd_i,
  gmr_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [gmr_pkg::CFG_BITS-1:0]   cfg_data_i
);

  localparam int CB       = COORD_BITS;
  localparam int RAD_FRAC = 32 - CB;
  localparam int CW       = ((CB + 2 > 31) ? CB + 2 : 31) + 4;
  localparam int SW       = CW + 2;
  localparam int ZW       = gmr_pkg::ZW;
  localparam logic signed [CW-1:0] HALF_R = CW'((64'd1 << RAD_FRAC) >> 1);

  function automatic logic signed [CB-1:0] sat_c(input logic signed [SW-1:0] v);
    logic [SW-CB:0] hi;
    logic signed [CB-1:0] r;
    hi = v[SW-1:CB-1];
    if (&hi || ~|hi) r = v[CB-1:0];
    else if (v[SW-1]) r = {1'b1, {(CB-1){1'b0}}};
    else r = {1'b0, {(CB-1){1'b1}}};
    return r;
  endfunction

  gmr_pkg::seq_state_e state_q, state_d;
  logic [gmr_pkg::ORIGIN_BITS-1:0] origin_x_q, origin_y_q;
  logic [gmr_pkg::HEIGHT_BITS-1:0] height_q;
  logic signed [CB-1:0] pos_x_q, pos_y_q, pos_z_q, oz_q, iv_q, jv_q;
  logic signed [CB:0]   cx_q, cy_q, abs_i, abs_j;
  logic                 extruding_q, moved_q, cw_q, he_q, neg_q;
  gmr_pkg::kind_e       kind_q, okind_q;
  logic [31:0]          mul_a, mul_b, rf_q, sa_q, ea_q, zrot_q, span, mid, ang, turn_t;
  logic [63:0]          prod_d, prod_q, acc_q;
  logic signed [CW-1:0] rx_q, ry_q, xr, yr, cor_x, cor_y, cor_xo, cor_yo;
  logic signed [ZW-1:0] cor_z;
  logic [31:0]          cor_zo;
  logic signed [CB-1:0] via_x_q, via_y_q, via_z_q;
  logic signed [CB-1:0] oend_x_q, oend_y_q, oend_z_q, ovia_x_q, ovia_y_q, ovia_z_q;
  logic                 ov_q, olast_q, out_free, accept, linear_hit, arc_hit;
  logic                 sq_start, sq_done, load_evt, load_move;
  logic [31:0]          sq_root;
  gmr_pkg::cor_req_t    cor_req;
  gmr_pkg::cor_status_t cor_status;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign out_free = !ov_q || res_o.ready;
  assign cmd_i.ready = (state_q == gmr_pkg::S_IDLE);

  assign linear_hit = (cmd_i.command == gmr_pkg::CMD_LINEAR) &&
                      ((cmd_i.has_x && cmd_i.has_y) ||
                       (cmd_i.has_z && !cmd_i.has_x && !cmd_i.has_y &&
                        cmd_i.z_value != pos_z_q));
  assign arc_hit = ((cmd_i.command == gmr_pkg::CMD_CW) ||
                    (cmd_i.command == gmr_pkg::CMD_CCW)) &&
                   cmd_i.has_i && cmd_i.has_j && cmd_i.has_x && cmd_i.has_y;

  assign abs_i  = iv_q[CB-1] ? -(CB+1)'(iv_q) : (CB+1)'(iv_q);
  assign abs_j  = jv_q[CB-1] ? -(CB+1)'(jv_q) : (CB+1)'(jv_q);
  assign prod_d = 64'(mul_a) * 64'(mul_b);

  assign span   = cw_q ? (sa_q - ea_q) : (ea_q - sa_q);
  assign mid    = cw_q ? (sa_q - (span >> 1)) : (sa_q + (span >> 1));
  assign turn_t = mid + gmr_pkg::QUARTER_TURN;
  assign ang    = turn_t[31] ? (mid - gmr_pkg::HALF_TURN) : mid;

  assign xr = neg_q ? -cor_xo : cor_xo;
  assign yr = neg_q ? -cor_yo : cor_yo;

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    cor_req   = '0;
    cor_x     = '0;
    cor_y     = '0;
    cor_z     = '0;
    sq_start  = 1'b0;
    load_evt  = 1'b0;
    load_move = 1'b0;
    case (state_q)
      gmr_pkg::S_IDLE: begin
        if (accept) begin
          if (linear_hit) state_d = gmr_pkg::S_EVT;
          else if (arc_hit) state_d = gmr_pkg::S_SQ_I;
        end
      end
      gmr_pkg::S_SQ_I: begin
        mul_a   = 32'(abs_i);
        mul_b   = 32'(abs_i);
        state_d = gmr_pkg::S_SQ_J;
      end
      gmr_pkg::S_SQ_J: begin
        mul_a   = 32'(abs_j);
        mul_b   = 32'(abs_j);
        state_d = gmr_pkg::S_SQRT;
      end
      gmr_pkg::S_SQRT: begin
        sq_start = 1'b1;
        state_d  = gmr_pkg::S_SQRT_W;
      end
      gmr_pkg::S_SQRT_W: begin
        if (sq_done) state_d = gmr_pkg::S_ANG_S;
      end
      gmr_pkg::S_ANG_S: begin
        cor_req.start = 1'b1;
        cor_x   = -CW'(iv_q);
        cor_y   = -CW'(jv_q);
        state_d = gmr_pkg::S_ANG_S_W;
      end
      gmr_pkg::S_ANG_S_W: begin
        if (cor_status.done) state_d = gmr_pkg::S_ANG_E;
      end
      gmr_pkg::S_ANG_E: begin
        cor_req.start = 1'b1;
        cor_x   = CW'(pos_x_q) - CW'(cx_q);
        cor_y   = CW'(pos_y_q) - CW'(cy_q);
        state_d = gmr_pkg::S_ANG_E_W;
      end
      gmr_pkg::S_ANG_E_W: begin
        if (cor_status.done) state_d = gmr_pkg::S_GAIN;
      end
      gmr_pkg::S_GAIN: begin
        mul_a   = rf_q;
        mul_b   = gmr_pkg::GAIN_Q30;
        state_d = gmr_pkg::S_ROT;
      end
      gmr_pkg::S_ROT: begin
        cor_req.start  = 1'b1;
        cor_req.rotate = 1'b1;
        cor_x   = signed'(CW'(prod_q[63:30]));
        cor_z   = ZW'(signed'(zrot_q));
        state_d = gmr_pkg::S_ROT_W;
      end
      gmr_pkg::S_ROT_W: begin
        if (cor_status.done) state_d = gmr_pkg::S_VIA;
      end
      gmr_pkg::S_VIA: state_d = gmr_pkg::S_EVT;
      gmr_pkg::S_EVT: begin
        if (he_q != extruding_q) begin
          if (out_free) begin
            load_evt = 1'b1;
            state_d  = gmr_pkg::S_MOVE;
          end
        end else begin
          state_d = gmr_pkg::S_MOVE;
        end
      end
      gmr_pkg::S_MOVE: begin
        if (out_free) begin
          load_move = 1'b1;
          state_d   = gmr_pkg::S_IDLE;
        end
      end
      default: state_d = gmr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmr_pkg::S_IDLE;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      height_q    <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      extruding_q <= 1'b0;
      moved_q     <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gmr_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
          gmr_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
          gmr_pkg::CFG_HEIGHT:   height_q   <= cfg_data_i[gmr_pkg::HEIGHT_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (cmd_i.has_x) pos_x_q <= cmd_i.x_value;
        if (cmd_i.has_y) pos_y_q <= cmd_i.y_value;
        if (cmd_i.has_z) pos_z_q <= cmd_i.z_value;
        if (linear_hit) moved_q <= 1'b1;
      end
      if (load_evt) extruding_q <= he_q;
      if (load_evt || load_move) ov_q <= 1'b1;
      else if (res_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      cw_q   <= (cmd_i.command == gmr_pkg::CMD_CW);
      he_q   <= cmd_i.has_e;
      iv_q   <= cmd_i.i_offset;
      jv_q   <= cmd_i.j_offset;
      cx_q   <= (CB+1)'(pos_x_q) + (CB+1)'(cmd_i.i_offset);
      cy_q   <= (CB+1)'(pos_y_q) + (CB+1)'(cmd_i.j_offset);
      oz_q   <= pos_z_q;
      kind_q <= linear_hit ? (moved_q ? gmr_pkg::KIND_LINEAR : gmr_pkg::KIND_FIRST)
                           : gmr_pkg::KIND_CIRC;
      if (linear_hit) begin
        via_x_q <= '0;
        via_y_q <= '0;
        via_z_q <= '0;
      end
    end
    if (state_q == gmr_pkg::S_SQ_J) acc_q <= prod_q;
    if (state_q == gmr_pkg::S_SQRT_W && sq_done) rf_q <= sq_root;
    if (state_q == gmr_pkg::S_ANG_S_W && cor_status.done) sa_q <= cor_zo;
    if (state_q == gmr_pkg::S_ANG_E_W && cor_status.done) ea_q <= cor_zo;
    if (state_q == gmr_pkg::S_GAIN) begin
      neg_q  <= turn_t[31];
      zrot_q <= ang;
    end
    if (state_q == gmr_pkg::S_ROT_W && cor_status.done) begin
      rx_q <= (xr + HALF_R) >>> RAD_FRAC;
      ry_q <= (yr + HALF_R) >>> RAD_FRAC;
    end
    if (state_q == gmr_pkg::S_VIA) begin
      via_x_q <= sat_c(SW'(cx_q) + SW'(rx_q) + signed'(SW'(origin_x_q)));
      via_y_q <= sat_c(SW'(cy_q) + SW'(ry_q) + signed'(SW'(origin_y_q)));
      via_z_q <= sat_c(((SW'(oz_q) + SW'(pos_z_q)) >>> 1) + signed'(SW'(height_q)));
    end
    if (load_evt) begin
      okind_q  <= he_q ? gmr_pkg::KIND_EXT_ON : gmr_pkg::KIND_EXT_OFF;
      oend_x_q <= '0;
      oend_y_q <= '0;
      oend_z_q <= '0;
      ovia_x_q <= '0;
      ovia_y_q <= '0;
      ovia_z_q <= '0;
      olast_q  <= 1'b0;
    end else if (load_move) begin
      okind_q  <= kind_q;
      oend_x_q <= sat_c(SW'(pos_x_q) + signed'(SW'(origin_x_q)));
      oend_y_q <= sat_c(SW'(pos_y_q) + signed'(SW'(origin_y_q)));
      oend_z_q <= sat_c(SW'(pos_z_q) + signed'(SW'(height_q)));
      ovia_x_q <= via_x_q;
      ovia_y_q <= via_y_q;
      ovia_z_q <= via_z_q;
      olast_q  <= 1'b1;
    end
  end

  gmr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .n_i     ((acc_q + prod_q) << (2 * RAD_FRAC)),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  gmr_cordic #(
    .CW           (CW),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (cor_req),
    .x_i      (cor_x),
    .y_i      (cor_y),
    .z_i      (cor_z),
    .status_o (cor_status),
    .x_o      (cor_xo),
    .y_o      (cor_yo),
    .z_o      (cor_zo)
  );

  assign res_o.valid = ov_q;
  assign res_o.kind  = okind_q;
  assign res_o.end_x = oend_x_q;
  assign res_o.end_y = oend_y_q;
  assign res_o.end_z = oend_z_q;
  assign res_o.via_x = ovia_x_q;
  assign res_o.via_y = ovia_y_q;
  assign res_o.via_z = ovia_z_q;
  assign res_o.last  = olast_q;

  `GMR_ASSERT(a_evt_not_last, res_o.valid && (res_o.kind == gmr_pkg::KIND_EXT_ON || res_o.kind == gmr_pkg::KIND_EXT_OFF) |-> !res_o.last, "extruder event marked as last")
  `GMR_ASSERT(a_via_zero, res_o.valid && res_o.kind != gmr_pkg::KIND_CIRC |-> res_o.via_x == '0 && res_o.via_y == '0 && res_o.via_z == '0, "non-circular result with via point")
  `GMR_ASSERT(a_cordic_owned, cor_status.busy |-> (state_q == gmr_pkg::S_ANG_S_W || state_q == gmr_pkg::S_ANG_E_W || state_q == gmr_pkg::S_ROT_W), "CORDIC busy outside a wait state")
  `GMR_ASSERT_NEXT(a_move_last, load_move, res_o.valid && res_o.last, "move not presented as last")
  `GMR_ASSERT_NEXT(a_moved_set, accept && linear_hit, moved_q, "linear move did not set moved flag")

endmodule
